// ===== src/smdm_pkg.sv =====
// shared constants, codes and types of the stereo modulated delay mixer
`default_nettype none

package smdm_pkg;

  localparam int DELAY_DEPTH     = 128;
  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;

  localparam int PTR_W      = $clog2(DELAY_DEPTH);
  localparam int FILL_W     = $clog2(DELAY_DEPTH + 1);
  localparam int CMP_W      = (FILL_W > 8) ? FILL_W + 1 : 9;
  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 32;
  localparam int BASE_W     = 6;
  localparam int GAIN_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [PHASE_BITS-1:0]      phase_t;
  typedef logic [BASE_W-1:0]          base_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  localparam logic [STEP_W-1:0] PHASE_STEP_RST = STEP_W'(116870);
  localparam base_t             BASE_DELAY_RST = BASE_W'(44);
  localparam gain_t             DEPTH_GAIN_RST = GAIN_W'(16384);
  localparam gain_t             DRY_GAIN_RST   = GAIN_W'(19275);
  localparam gain_t             WET_GAIN_RST   = GAIN_W'(13493);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 3'd0,
    CFG_BASE_DELAY = 3'd1,
    CFG_DEPTH_GAIN = 3'd2,
    CFG_DRY_GAIN   = 3'd3,
    CFG_WET_GAIN   = 3'd4
  } cfg_reg_t;

  // one strobe per step of the per-sample sequence, the final output step apart
  typedef struct packed {
    logic start;
    logic mod;
    logic ofs;
    logic rdr;
    logic wl;
  } seq_ctrl_t;

endpackage

`default_nettype wire

// ===== src/smdm_ifs.sv =====
// valid/ready interfaces for the sample, result and register write channels
`default_nettype none

interface smdm_in_if;
  import smdm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface smdm_out_if;
  import smdm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

interface smdm_cfg_if;
  import smdm_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/smdm_lfo.sv =====
// phase accumulator and quadrature sine lookup of the modulation oscillator
`default_nettype none

module smdm_lfo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire smdm_pkg::seq_ctrl_t ctrl,
  input  wire smdm_pkg::phase_t    phase_step,
  output smdm_pkg::sample_t        cos_val,
  output smdm_pkg::sample_t        sin_val
);
  import smdm_pkg::*;

  localparam int QIDX_W      = SINE_TABLE_BITS - 2;
  localparam int QUARTER_LEN = 1 << QIDX_W;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ROUND_HALF  = 64'd1 << 29;
  localparam logic [63:0] FULL_SCALE  = 64'd32767;
  localparam logic [63:0] TAYLOR_DIV [1:5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

  typedef logic [14:0] qtab_t [0:QUARTER_LEN];

  // quarter wave, taylor series to the eleventh power
  function automatic qtab_t build_qtab();
    qtab_t              t;
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] s;
    int                 k;
    int                 i;
    for (k = 0; k <= QUARTER_LEN; k++) begin
      a    = (64'(k) * HALF_PI_Q30) / QUARTER_LEN;
      a2   = (a * a) >> 30;
      term = a;
      s    = $signed(a);
      for (i = 1; i <= 5; i++) begin
        term = ((term * a2) >> 30) / TAYLOR_DIV[i];
        if (i % 2 == 1) begin
          s = s - $signed(term);
        end else begin
          s = s + $signed(term);
        end
      end
      if (s < 0) begin
        s = '0;
      end
      v = ($unsigned(s) * FULL_SCALE + ROUND_HALF) >> 30;
      if (v > FULL_SCALE) begin
        v = FULL_SCALE;
      end
      t[k] = v[14:0];
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  function automatic sample_t sine_at(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [QIDX_W:0] tidx;
    logic [14:0]     mag;
    sample_t         pos;
    if (idx[SINE_TABLE_BITS-2]) begin
      tidx = (QIDX_W+1)'(QUARTER_LEN) - {1'b0, idx[QIDX_W-1:0]};
    end else begin
      tidx = {1'b0, idx[QIDX_W-1:0]};
    end
    mag = QTAB[tidx];
    pos = $signed({1'b0, mag});
    return idx[SINE_TABLE_BITS-1] ? -pos : pos;
  endfunction

  phase_t                     phase_r;
  sample_t                    cos_r;
  sample_t                    sin_r;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS-1:0] idx_cos;

  assign idx     = phase_r[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign idx_cos = idx + SINE_TABLE_BITS'(QUARTER_LEN);

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cos_r <= sine_at(idx_cos);
      sin_r <= sine_at(idx);
    end
    if (!rst_n) begin
      phase_r <= '0;
    end else if (ctrl.start) begin
      phase_r <= phase_r + phase_step;
    end
  end

  assign cos_val = cos_r;
  assign sin_val = sin_r;

endmodule

`default_nettype wire

// ===== src/smdm_delay.sv =====
// sample history memory with modulated tap offsets and read sequencing
`default_nettype none

module smdm_delay (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire smdm_pkg::seq_ctrl_t ctrl,
  input  wire smdm_pkg::base_t     base_delay,
  input  wire smdm_pkg::gain_t     depth_gain,
  input  wire smdm_pkg::sample_t   cos_val,
  input  wire smdm_pkg::sample_t   sin_val,
  input  wire smdm_pkg::sample_t   x,
  output smdm_pkg::sample_t        tap
);
  import smdm_pkg::*;

  localparam int M_W     = BASE_W + GAIN_W;
  localparam int PROD_W  = M_W + 1 + SAMPLE_W;
  localparam int OFS_W   = 10;
  localparam int FRAC_SH = 29;

  function automatic logic [CMP_W-1:0] pos_off(input base_t b,
                                               input logic signed [PROD_W-1:0] p);
    logic signed [OFS_W-1:0] o;
    o = $signed({{(OFS_W-BASE_W){1'b0}}, b}) + OFS_W'(p >>> FRAC_SH);
    if (o < 0) begin
      return '0;
    end
    return CMP_W'(o);
  endfunction

  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] wp,
                                               input logic [CMP_W-1:0] off);
    logic [CMP_W-1:0] w;
    w = CMP_W'(wp);
    if (w >= off) begin
      return PTR_W'(w - off);
    end
    return PTR_W'(w + CMP_W'(DELAY_DEPTH) - off);
  endfunction

  sample_t                   mem [DELAY_DEPTH];
  sample_t                   rdata_r;
  logic [PTR_W-1:0]          wp_r;
  logic [FILL_W-1:0]         fill_r;
  logic [M_W-1:0]            m_r;
  logic signed [PROD_W-1:0]  pc_r;
  logic signed [PROD_W-1:0]  ps_r;
  logic [PTR_W-1:0]          slot_rt_r;
  logic                      use_lt_r;
  logic                      use_rt_r;
  logic [CMP_W-1:0]          off_l;
  logic [CMP_W-1:0]          off_r;
  logic                      use_l;
  logic                      use_r;
  logic [PTR_W-1:0]          raddr;
  logic                      tap_hist;

  assign off_l = pos_off(base_delay, pc_r);
  assign off_r = pos_off(base_delay, ps_r);
  assign use_l = (off_l != '0) && (off_l <= CMP_W'(fill_r));
  assign use_r = (off_r != '0) && (off_r <= CMP_W'(fill_r));
  assign raddr = ctrl.ofs ? slot_of(wp_r, off_l) : slot_rt_r;

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (ctrl.wl) begin
      mem[wp_r] <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      m_r <= base_delay * depth_gain;
    end
    if (ctrl.mod) begin
      pc_r <= $signed({1'b0, m_r}) * cos_val;
      ps_r <= $signed({1'b0, m_r}) * sin_val;
    end
    if (ctrl.ofs) begin
      slot_rt_r <= slot_of(wp_r, off_r);
      use_lt_r  <= use_l;
      use_rt_r  <= use_r;
    end
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (ctrl.wl) begin
      wp_r <= (wp_r == PTR_W'(DELAY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (fill_r != FILL_W'(DELAY_DEPTH)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // history sample only for an offset that is nonzero and already seen
  assign tap_hist = ctrl.rdr ? use_lt_r : use_rt_r;
  assign tap      = tap_hist ? rdata_r : x;

endmodule

`default_nettype wire

// ===== src/smdm_mix.sv =====
// dry/wet gain multiply, truncation toward zero and saturation
`default_nettype none

module smdm_mix (
  input  wire logic                clk,
  input  wire smdm_pkg::seq_ctrl_t ctrl,
  input  wire smdm_pkg::gain_t     dry_gain,
  input  wire smdm_pkg::gain_t     wet_gain,
  input  wire smdm_pkg::sample_t   x,
  input  wire smdm_pkg::sample_t   tap,
  output smdm_pkg::sample_t        left_val,
  output smdm_pkg::sample_t        right_val
);
  import smdm_pkg::*;

  localparam int PRD_W = GAIN_W + 1 + SAMPLE_W;
  localparam int MIX_W = PRD_W + 1;
  localparam int Q_W   = MIX_W - 15;

  function automatic sample_t mix_sat(input logic signed [MIX_W-1:0] s);
    logic signed [Q_W-1:0] q;
    q = Q_W'(s >>> 15);
    if (s < 0 && s[14:0] != '0) begin
      q = q + 1'b1;
    end
    if (q > $signed(Q_W'(32767))) begin
      return 16'sh7fff;
    end
    if (q < -$signed(Q_W'(32768))) begin
      return 16'sh8000;
    end
    return q[SAMPLE_W-1:0];
  endfunction

  logic signed [PRD_W-1:0] dryx_r;
  logic signed [PRD_W-1:0] wetp_r;
  sample_t                 left_r;

  always_ff @(posedge clk) begin
    if (ctrl.mod) begin
      dryx_r <= $signed({1'b0, dry_gain}) * x;
    end
    if (ctrl.rdr || ctrl.wl) begin
      wetp_r <= $signed({1'b0, wet_gain}) * tap;
    end
    if (ctrl.wl) begin
      left_r <= mix_sat(MIX_W'(dryx_r) + MIX_W'(wetp_r));
    end
  end

  assign left_val  = left_r;
  assign right_val = mix_sat(MIX_W'(dryx_r) + MIX_W'(wetp_r));

endmodule

`default_nettype wire

// ===== src/stereo_modulated_delay_mixer_core.sv =====
// top level of the stereo modulated delay mixer: registers, sequencer, output stage
//
//   channel  dir  payload                      transfer
//   cfg_ch   in   index[2:0], data[31:0]       valid && ready, ready always high
//   in_ch    in   sample_in[15:0] signed       valid && ready, ready in idle
//   out_ch   out  left_out, right_out signed   valid && ready
//
// one sample runs through six steps: accept, modulation multiply, offset and left read,
// right read, left mix and history write, right mix into the output register
// the single-port history memory sets the two reads apart; next accept follows
// reset clears sequencer, oscillator phase, write pointer and fill count
// a stalled output holds the last step until the result register is free
`default_nettype none

module stereo_modulated_delay_mixer_core (
  input wire logic  clk,
  input wire logic  rst_n,
  smdm_cfg_if.sink  cfg_ch,
  smdm_in_if.sink   in_ch,
  smdm_out_if.source out_ch
);
  import smdm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_OFS,
    ST_RDR,
    ST_WL,
    ST_FIN
  } state_t;

  state_t    state_r;
  phase_t    phase_step_r;
  base_t     base_delay_r;
  gain_t     depth_gain_r;
  gain_t     dry_gain_r;
  gain_t     wet_gain_r;
  sample_t   x_r;
  sample_t   left_out_r;
  sample_t   right_out_r;
  logic      out_valid_r;
  seq_ctrl_t ctrl;
  sample_t   cos_val;
  sample_t   sin_val;
  sample_t   tap;
  sample_t   left_val;
  sample_t   right_val;
  logic      load_out;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);

  assign ctrl.start = in_ch.valid && in_ch.ready;
  assign ctrl.mod   = (state_r == ST_MOD);
  assign ctrl.ofs   = (state_r == ST_OFS);
  assign ctrl.rdr   = (state_r == ST_RDR);
  assign ctrl.wl    = (state_r == ST_WL);

  assign load_out = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RST[PHASE_BITS-1:0];
      base_delay_r <= BASE_DELAY_RST;
      depth_gain_r <= DEPTH_GAIN_RST;
      dry_gain_r   <= DRY_GAIN_RST;
      wet_gain_r   <= WET_GAIN_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_reg_t'(cfg_ch.index))
        CFG_PHASE_STEP: phase_step_r <= cfg_ch.data[PHASE_BITS-1:0];
        CFG_BASE_DELAY: base_delay_r <= cfg_ch.data[BASE_W-1:0];
        CFG_DEPTH_GAIN: depth_gain_r <= cfg_ch.data[GAIN_W-1:0];
        CFG_DRY_GAIN:   dry_gain_r   <= cfg_ch.data[GAIN_W-1:0];
        CFG_WET_GAIN:   wet_gain_r   <= cfg_ch.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x_r <= in_ch.sample_in;
    end
    if (load_out) begin
      left_out_r  <= left_val;
      right_out_r <= right_val;
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (ctrl.start) begin
            state_r <= ST_MOD;
          end
        end
        ST_MOD: state_r <= ST_OFS;
        ST_OFS: state_r <= ST_RDR;
        ST_RDR: state_r <= ST_WL;
        ST_WL:  state_r <= ST_FIN;
        ST_FIN: begin
          if (load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = left_out_r;
  assign out_ch.right_out = right_out_r;

  smdm_lfo u_lfo (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .phase_step (phase_step_r),
    .cos_val    (cos_val),
    .sin_val    (sin_val)
  );

  smdm_delay u_delay (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .base_delay (base_delay_r),
    .depth_gain (depth_gain_r),
    .cos_val    (cos_val),
    .sin_val    (sin_val),
    .x          (x_r),
    .tap        (tap)
  );

  smdm_mix u_mix (
    .clk       (clk),
    .ctrl      (ctrl),
    .dry_gain  (dry_gain_r),
    .wet_gain  (wet_gain_r),
    .x         (x_r),
    .tap       (tap),
    .left_val  (left_val),
    .right_val (right_val)
  );

endmodule

`default_nettype wire
